### src/servo_status_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Servo status frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_FRAME_PARSER_MACROS_SVH
`define SERVO_STATUS_FRAME_PARSER_MACROS_SVH

// The condition holds at every clock edge.
`define SSFP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SSFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ssfp_pkg.sv
// ----------------------------------------------------------------------------
// Servo status frame parser package
// Codes, widths and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ssfp_pkg;

  localparam int PAYLOAD_MAX_DEFAULT = 24;

  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 8;
  localparam int TICK_W    = 16;
  localparam int OC_W      = 3;
  localparam int OUT_CNT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_ARM  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  localparam logic [OC_W-1:0] OC_OK        = 3'd0;
  localparam logic [OC_W-1:0] OC_TIMEOUT   = 3'd1;
  localparam logic [OC_W-1:0] OC_BAD_LEN   = 3'd2;
  localparam logic [OC_W-1:0] OC_BAD_CSUM  = 3'd3;
  localparam logic [OC_W-1:0] OC_WRONG_ID  = 3'd4;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hF5;
  localparam logic [LEN_W-1:0]  LEN_MIN    = 8'd2;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;

  typedef struct packed {
    logic            arm;
    logic            tick_inc;
    logic            tick_clr;
    logic            prev_load;
    logic            id_load;
    logic            len_load;
    logic            body_store;
    logic            emit_start;
    logic            rd_issue;
    logic            emit_adv;
    logic            res_load;
    logic [OC_W-1:0] res_oc;
    logic            res_status;
    logic            res_param;
    logic            res_last;
  } ssfp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hdr_match;
    logic tick_expire;
    logic len_bad;
    logic body_last;
    logic sum_ok;
    logic id_ok;
    logic count_zero;
    logic emit_last;
  } ssfp_sts_t;

endpackage

### src/ssfp_ctrl.sv
// ----------------------------------------------------------------------------
// Servo status frame parser controller
// Frame phase state machine; decodes each accepted item into datapath
// commands and sequences the parameter burst.
// ----------------------------------------------------------------------------
module ssfp_ctrl
  import ssfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [FUNC_W-1:0] func,
  output logic              item_stall,
  input  ssfp_sts_t         sts,
  output ssfp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HUNT = 3'd1;
  localparam logic [2:0] S_ID   = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_BODY = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       emitting;
  logic       busy;
  logic       item_fire;

  assign emitting   = (state == S_RD) || (state == S_LOAD);
  assign busy       = (state == S_HUNT) || (state == S_ID) ||
                      (state == S_LEN) || (state == S_BODY);
  assign item_stall = emitting || !sts.out_free;
  assign item_fire  = item_valid && !item_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (item_fire) begin
      unique case (func)
        FUNC_ARM: begin
          cmd.arm    = 1'b1;
          state_next = S_HUNT;
        end
        FUNC_TICK: begin
          if (busy) begin
            cmd.tick_inc = 1'b1;
            if (sts.tick_expire) begin
              cmd.res_load = 1'b1;
              cmd.res_oc   = OC_TIMEOUT;
              cmd.res_last = 1'b1;
              state_next   = S_IDLE;
            end
          end
        end
        FUNC_BYTE: begin
          unique case (state)
            S_HUNT: begin
              if (sts.hdr_match) begin
                cmd.tick_clr = 1'b1;
                state_next   = S_ID;
              end else begin
                cmd.prev_load = 1'b1;
              end
            end
            S_ID: begin
              cmd.id_load = 1'b1;
              state_next  = S_LEN;
            end
            S_LEN: begin
              cmd.len_load = 1'b1;
              if (sts.len_bad) begin
                cmd.res_load = 1'b1;
                cmd.res_oc   = OC_BAD_LEN;
                cmd.res_last = 1'b1;
                state_next   = S_IDLE;
              end else begin
                state_next = S_BODY;
              end
            end
            S_BODY: begin
              cmd.body_store = 1'b1;
              if (sts.body_last) begin
                state_next = S_IDLE;
                if (!sts.sum_ok) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_oc     = OC_BAD_CSUM;
                  cmd.res_status = 1'b1;
                  cmd.res_last   = 1'b1;
                end else if (!sts.id_ok) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_oc     = OC_WRONG_ID;
                  cmd.res_status = 1'b1;
                  cmd.res_last   = 1'b1;
                end else if (sts.count_zero) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_oc     = OC_OK;
                  cmd.res_status = 1'b1;
                  cmd.res_last   = 1'b1;
                end else begin
                  cmd.emit_start = 1'b1;
                  state_next     = S_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state)
        S_RD: begin
          cmd.rd_issue = 1'b1;
          state_next   = S_LOAD;
        end
        S_LOAD: begin
          if (sts.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_oc     = OC_OK;
            cmd.res_status = 1'b1;
            cmd.res_param  = 1'b1;
            cmd.res_last   = sts.emit_last;
            cmd.emit_adv   = 1'b1;
            state_next     = sts.emit_last ? S_IDLE : S_RD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ssfp_dp.sv
// ----------------------------------------------------------------------------
// Servo status frame parser datapath
// Frame registers, checksum, timeout counter, payload memory and the
// result register.
// ----------------------------------------------------------------------------
module ssfp_dp
  import ssfp_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    data,
  input  ssfp_cmd_t            cmd,
  output ssfp_sts_t            sts,
  input  logic                 result_stall,
  output logic                 result_valid,
  output logic [OC_W-1:0]      outcome,
  output logic [BYTE_W-1:0]    servo_id,
  output logic [BYTE_W-1:0]    servo_status,
  output logic [OUT_CNT_W-1:0] param_count,
  output logic [OUT_CNT_W-1:0] param_index,
  output logic [BYTE_W-1:0]    param_byte,
  output logic                 last
);

  localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
  localparam int ADDR_W = $clog2(PAYLOAD_MAX);

  logic [TICK_W-1:0] timeout_ticks;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_inc_val;
  logic [BYTE_W-1:0] prev_byte;
  logic [BYTE_W-1:0] want_id;
  logic [BYTE_W-1:0] got_id;
  logic [LEN_W-1:0]  got_len;
  logic [LEN_W-1:0]  count;
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] status_byte;
  logic [CNT_W-1:0]  emit_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_MAX];

  assign tick_inc_val = tick_count + TICK_W'(1);
  assign count        = got_len - LEN_MIN;
  assign rd_addr      = ADDR_W'(emit_idx + CNT_W'(1));

  always_comb begin
    sts.out_free    = !result_valid || !result_stall;
    sts.hdr_match   = (prev_byte == HDR_FIRST) && (data == HDR_SECOND);
    sts.tick_expire = tick_inc_val >= timeout_ticks;
    sts.len_bad     = (data < LEN_MIN) || (data > LEN_W'(PAYLOAD_MAX));
    sts.body_last   = (LEN_W'(byte_count) + LEN_W'(1)) == got_len;
    sts.sum_ok      = ~running_sum == data;
    sts.id_ok       = got_id == want_id;
    sts.count_zero  = got_len == LEN_MIN;
    sts.emit_last   = (LEN_W'(emit_idx) + LEN_W'(1)) == count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      prev_byte   <= '0;
      want_id     <= '0;
      got_id      <= '0;
      got_len     <= '0;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      if (cmd.arm) begin
        want_id     <= data;
        tick_count  <= '0;
        prev_byte   <= '0;
        got_id      <= '0;
        got_len     <= '0;
        byte_count  <= '0;
        running_sum <= '0;
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_inc_val;
      end
      if (cmd.tick_clr) begin
        tick_count <= '0;
      end
      if (cmd.prev_load) begin
        prev_byte <= data;
      end
      if (cmd.id_load) begin
        got_id      <= data;
        running_sum <= data;
      end
      if (cmd.len_load) begin
        got_len     <= data;
        running_sum <= running_sum + data;
        byte_count  <= '0;
      end
      if (cmd.body_store) begin
        running_sum <= running_sum + data;
        byte_count  <= byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.body_store && (byte_count == '0)) begin
      status_byte <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.emit_adv) begin
      emit_idx <= emit_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.body_store) begin
      payload_mem[byte_count[ADDR_W-1:0]] <= data;
    end
    if (cmd.rd_issue) begin
      rd_data <= payload_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.res_load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      outcome      <= cmd.res_oc;
      servo_id     <= got_id;
      servo_status <= cmd.res_status ? status_byte : '0;
      param_count  <= cmd.res_param ? count[OUT_CNT_W-1:0] : '0;
      param_index  <= cmd.res_param ? OUT_CNT_W'(emit_idx) : '0;
      param_byte   <= cmd.res_param ? rd_data : '0;
      last         <= cmd.res_last;
    end
  end

endmodule

### src/servo_status_frame_parser.sv
// ----------------------------------------------------------------------------
// Servo status frame parser
// Parses servo reply frames (FF F5, id, length, status, parameters,
// inverted-sum checksum) and reports one outcome per armed attempt.
// ----------------------------------------------------------------------------
// Items enter on the item channel (item_valid, item_stall, func, data): an arm
// with the expected id, a received byte, or a one millisecond tick. Results
// leave on the result channel (result_valid, result_stall and the fields).
// cfg_write with cfg_data sets the timeout in ticks, reset value 20; the user must
// write it only while no attempt is in flight, the block itself does not enforce it.
// A result without a parameter byte is shown in the cycle after the accepting
// edge. A good frame with parameters produces a burst of one result per
// parameter byte; each is read from the payload memory in the read state and
// loaded into the result register in the load state once that register is free,
// because the payload memory has one registered read port, and the item channel
// stalls for the length of the burst. Items are accepted back to back otherwise.
// While result_stall holds a result, it stays put and item_stall is raised.
// Reset (rst, synchronous) drops any attempt, empties the result register
// and restores the timeout; bytes and ticks before the first arm are ignored.
// ----------------------------------------------------------------------------
module servo_status_frame_parser
  import ssfp_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [BYTE_W-1:0]    data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [OC_W-1:0]      outcome,
  output logic [BYTE_W-1:0]    servo_id,
  output logic [BYTE_W-1:0]    servo_status,
  output logic [OUT_CNT_W-1:0] param_count,
  output logic [OUT_CNT_W-1:0] param_index,
  output logic [BYTE_W-1:0]    param_byte,
  output logic                 last
);

  ssfp_cmd_t cmd;
  ssfp_sts_t sts;

  ssfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .func       (func),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssfp_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .data         (data),
    .cmd          (cmd),
    .sts          (sts),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .outcome      (outcome),
    .servo_id     (servo_id),
    .servo_status (servo_status),
    .param_count  (param_count),
    .param_index  (param_index),
    .param_byte   (param_byte),
    .last         (last)
  );

endmodule

### src/ssfp_checker.sv
// ----------------------------------------------------------------------------
// Servo status frame parser checker
// Port-level assertions on the result and item channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "servo_status_frame_parser_macros.svh"

module ssfp_checker
  import ssfp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic [OC_W-1:0]      outcome,
  input logic [BYTE_W-1:0]    param_byte,
  input logic [OUT_CNT_W-1:0] param_count,
  input logic [OUT_CNT_W-1:0] param_index,
  input logic                 last
);

  `SSFP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(outcome) && $stable(param_byte) && $stable(last), "Stalled result changed.")
  `SSFP_ASSERT_SAME(a_item_blocked, result_valid && result_stall, item_stall, "Item accepted while a result is held.")
  `SSFP_ASSERT_SAME(a_fail_single, result_valid && (outcome != OC_OK), last && (param_count == '0) && (param_byte == '0), "Failed attempt is not a single final result.")
  `SSFP_ASSERT_SAME(a_index_range, result_valid && (param_count != '0), param_index < param_count, "Parameter position beyond the count.")

endmodule

bind servo_status_frame_parser ssfp_checker u_ssfp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .outcome      (outcome),
  .param_byte   (param_byte),
  .param_count  (param_count),
  .param_index  (param_index),
  .last         (last)
);
